FILE: hw/rtl/nsc_pkg.sv
// NMEA sentence checker package: character codes, limits and the result record.
// Used by every module of the checker.
`default_nettype none
package nsc_pkg;

  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;

  localparam logic [23:0] TailGga = 24'h474741;
  localparam logic [23:0] TailZda = 24'h5A4441;

  localparam logic [7:0] MaxSentenceLen = 8'd82;
  localparam logic [4:0] CommaMax       = 5'd30;
  localparam logic [6:0] ByteCountMax   = 7'd127;
  localparam logic [1:0] HexDigitsFull  = 2'd2;

  typedef enum logic [1:0] {
    TYPE_OTHER = 2'd0,
    TYPE_GGA   = 2'd1,
    TYPE_ZDA   = 2'd2
  } sentence_type_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_STAR  = 2'd1,
    STATUS_MISMATCH = 2'd2,
    STATUS_TOO_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0] sentence_type;
    logic [1:0] status;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [4:0] field_count;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/nsc_byte_if.sv
// Byte request channel of the NMEA sentence checker.
// Carries one received byte with a valid/ready handshake.
`default_nettype none
interface nsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/nsc_result_if.sv
// Result request channel of the NMEA sentence checker.
// Carries one sentence result with a valid/ready handshake.
`default_nettype none
interface nsc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_type;
  logic [1:0] status;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;
  logic [4:0] field_count;

  modport source (output valid, output sentence_type, output status,
                  output computed_checksum, output received_checksum,
                  output field_count, input ready);
  modport sink (input valid, input sentence_type, input status,
                input computed_checksum, input received_checksum,
                input field_count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/nsc_parser.sv
// Sentence parser: per-byte state update and result formation on a terminator.
// Depends on nsc_pkg.
`default_nettype none
module nsc_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [7:0]      rx_byte,
  output logic                 res_valid,
  output nsc_pkg::result_t     res_data
);
  import nsc_pkg::*;

  logic        in_sentence, in_sentence_next;
  logic [7:0]  running_xor, running_xor_next;
  logic        star_seen, star_seen_next;
  logic [1:0]  hex_digits_seen, hex_digits_seen_next;
  logic [7:0]  hex_value, hex_value_next;
  logic        hex_bad, hex_bad_next;
  logic [23:0] address_tail, address_tail_next;
  logic        in_address, in_address_next;
  logic [4:0]  comma_count, comma_count_next;
  logic [6:0]  byte_count, byte_count_next;

  logic        is_term;
  logic        emit;
  logic [4:0]  nib;
  logic [7:0]  total_len;

  function automatic logic [4:0] nibble_of(input logic [7:0] b);
    logic [4:0] n;
    n = 5'd16;
    if (b >= 8'h30 && b <= 8'h39) n = 5'(b - 8'h30);
    else if (b >= 8'h41 && b <= 8'h46) n = 5'(b - 8'h41 + 8'd10);
    else if (b >= 8'h61 && b <= 8'h66) n = 5'(b - 8'h61 + 8'd10);
    return n;
  endfunction

  assign is_term   = (rx_byte == ChCr) || (rx_byte == ChLf);
  assign nib       = nibble_of(rx_byte);
  assign total_len = {1'b0, byte_count} + 8'd3;

  always_comb begin
    in_sentence_next     = in_sentence;
    running_xor_next     = running_xor;
    star_seen_next       = star_seen;
    hex_digits_seen_next = hex_digits_seen;
    hex_value_next       = hex_value;
    hex_bad_next         = hex_bad;
    address_tail_next    = address_tail;
    in_address_next      = in_address;
    comma_count_next     = comma_count;
    byte_count_next      = byte_count;
    emit                 = 1'b0;

    if (rx_byte == ChDollar || (in_sentence && is_term)) begin
      running_xor_next     = '0;
      star_seen_next       = 1'b0;
      hex_digits_seen_next = '0;
      hex_value_next       = '0;
      hex_bad_next         = 1'b0;
      address_tail_next    = '0;
      comma_count_next     = '0;
      byte_count_next      = '0;
      in_sentence_next     = (rx_byte == ChDollar);
      in_address_next      = (rx_byte == ChDollar);
      emit                 = (rx_byte != ChDollar) && (byte_count != '0);
    end else if (in_sentence) begin
      if (byte_count < ByteCountMax) byte_count_next = byte_count + 7'd1;
      if (!star_seen) begin
        if (rx_byte == ChStar) begin
          star_seen_next  = 1'b1;
          in_address_next = 1'b0;
        end else begin
          running_xor_next = running_xor ^ rx_byte;
          if (rx_byte == ChComma) begin
            if (comma_count < CommaMax) comma_count_next = comma_count + 5'd1;
            in_address_next = 1'b0;
          end else if (in_address) begin
            address_tail_next = {address_tail[15:0], rx_byte};
          end
        end
      end else if (hex_digits_seen < HexDigitsFull) begin
        if (nib[4]) hex_bad_next = 1'b1;
        hex_value_next       = {hex_value[3:0], (nib[4] ? 4'h0 : nib[3:0])};
        hex_digits_seen_next = hex_digits_seen + 2'd1;
      end
    end
  end

  always_comb begin
    if (address_tail == TailGga) res_data.sentence_type = TYPE_GGA;
    else if (address_tail == TailZda) res_data.sentence_type = TYPE_ZDA;
    else res_data.sentence_type = TYPE_OTHER;

    if (total_len > MaxSentenceLen) res_data.status = STATUS_TOO_LONG;
    else if (!star_seen) res_data.status = STATUS_NO_STAR;
    else if (hex_bad || hex_digits_seen < HexDigitsFull || hex_value != running_xor)
      res_data.status = STATUS_MISMATCH;
    else res_data.status = STATUS_OK;

    res_data.computed_checksum = running_xor;
    res_data.received_checksum = star_seen ? hex_value : 8'h00;
    res_data.field_count       = comma_count + 5'd1;
  end

  assign res_valid = take && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence     <= 1'b0;
      running_xor     <= '0;
      star_seen       <= 1'b0;
      hex_digits_seen <= '0;
      hex_value       <= '0;
      hex_bad         <= 1'b0;
      address_tail    <= '0;
      in_address      <= 1'b0;
      comma_count     <= '0;
      byte_count      <= '0;
    end else if (take) begin
      in_sentence     <= in_sentence_next;
      running_xor     <= running_xor_next;
      star_seen       <= star_seen_next;
      hex_digits_seen <= hex_digits_seen_next;
      hex_value       <= hex_value_next;
      hex_bad         <= hex_bad_next;
      address_tail    <= address_tail_next;
      in_address      <= in_address_next;
      comma_count     <= comma_count_next;
      byte_count      <= byte_count_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (in_sentence && byte_count != '0))
    else $error("result without an open, non-empty sentence");
  assert property (@(posedge clk) disable iff (rst)
    (take && rx_byte == ChDollar) |=> (in_sentence && byte_count == '0 && !star_seen))
    else $error("sentence start did not reopen the sentence");
  assert property (@(posedge clk) disable iff (rst)
    (hex_digits_seen <= HexDigitsFull) && (comma_count <= CommaMax))
    else $error("digit or comma counter out of range");
  assert property (@(posedge clk) disable iff (rst)
    (!star_seen) |-> (hex_digits_seen == '0 && hex_value == '0 && !hex_bad))
    else $error("checksum digits recorded before the star");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/nsc_out_buf.sv
// Result output register with a skid stage so bytes keep flowing while a result waits.
// Depends on nsc_pkg and nsc_result_if.
`default_nettype none
module nsc_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire nsc_pkg::result_t  push_data,
  output logic                   in_ready,
  nsc_result_if.source           res
);
  import nsc_pkg::*;

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    drain;

  assign in_ready = !skid_valid;
  assign drain    = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign res.valid             = out_valid;
  assign res.sentence_type     = out_data.sentence_type;
  assign res.status            = out_data.status;
  assign res.computed_checksum = out_data.computed_checksum;
  assign res.received_checksum = out_data.received_checksum;
  assign res.field_count       = out_data.field_count;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a request while the output register is empty");
  assert property (@(posedge clk) disable iff (rst)
    (push && !drain) |=> skid_valid)
    else $error("request lost while the output register stalled");
`endif
endmodule
`default_nettype wire

FILE: hw/rtl/nmea_sentence_checker_core.sv
// NMEA sentence checker: one received byte accepted per cycle, no bubbles, except while the input stalls.
// The result of a sentence ending in CR or LF goes into the output register, or into the skid stage if that stalls.
// Throughput: one byte per cycle while the input is not stalled; the parser updates its state on each accepted byte.
// Input stalls only when both the output register and the skid stage hold results.
// Synchronous active-high reset clears parser state and empties the output stages.
`default_nettype none
module nmea_sentence_checker_core (
  input  wire logic     clk,
  input  wire logic     rst,
  nsc_byte_if.sink      rx,
  nsc_result_if.source  res
);
  import nsc_pkg::*;

  logic    take;
  logic    in_ready;
  logic    res_valid;
  result_t res_data;

  assign rx.ready = in_ready;
  assign take     = rx.valid && in_ready;

  nsc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rx_byte   (rx.rx_byte),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  nsc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res_data),
    .in_ready  (in_ready),
    .res       (res)
  );
endmodule
`default_nettype wire
